// File: hdl/swept_aabb_collision_test_defines.svh
// Assertion macros for the swept box collision test.
`ifndef SWEPT_AABB_COLLISION_TEST_DEFINES_SVH
`define SWEPT_AABB_COLLISION_TEST_DEFINES_SVH
`ifndef ASSERT_OFF
// Implication in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication after a fixed number of cycles.
`define ASSERT_DELAYED(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_DELAYED(label, clk, rst_n, ante, dly, cons)
`endif
`endif

// File: hdl/saabb_pkg.sv
// ---------------------------------------------------------------------------
// Swept box collision package
// Word types, widths and register indexes shared by the collision test.
// ---------------------------------------------------------------------------
package saabb_pkg;

    // Fraction bits of the time results.
    localparam int FRAC_BITS = 16;
    // Coordinate and velocity width.
    localparam int CW = 32;
    // Time field width.
    localparam int TW = 23;
    // Saturating quotient width: one bit above the time field.
    localparam int QW = TW + 1;
    // Distance and speed magnitude width.
    localparam int DW = CW;
    // Dividend width.
    localparam int NW = DW + FRAC_BITS;
    // Remainder width inside the divider.
    localparam int RW = DW + QW;
    // Epsilon register width.
    localparam int EW = 17;
    // Divider latency in cycles.
    localparam int DIV_LAT = QW + 1;
    // Start to result latency.
    localparam int LATENCY = DIV_LAT + 5;

    // Register indexes.
    localparam logic CFG_FRAME_TIME = 1'b0;
    localparam logic CFG_SPEED_EPS  = 1'b1;
    localparam logic [TW-1:0] FRAME_TIME_RST = TW'(1092);
    localparam logic [EW-1:0] SPEED_EPS_RST  = EW'(66);

    typedef struct packed {
        logic signed [CW-1:0] a_min_x;
        logic signed [CW-1:0] a_min_y;
        logic signed [CW-1:0] a_max_x;
        logic signed [CW-1:0] a_max_y;
        logic signed [CW-1:0] b_min_x;
        logic signed [CW-1:0] b_min_y;
        logic signed [CW-1:0] b_max_x;
        logic signed [CW-1:0] b_max_y;
        logic signed [CW-1:0] a_vel_x;
        logic signed [CW-1:0] a_vel_y;
        logic signed [CW-1:0] b_vel_x;
        logic signed [CW-1:0] b_vel_y;
    } t_in_word;

    typedef struct packed {
        logic          hit;
        logic          already_overlapping;
        logic [TW-1:0] t_first;
    } t_out_word;

endpackage

// File: hdl/swept_aabb_collision_test.sv
// ---------------------------------------------------------------------------
// Swept box collision test
// Two moving boxes in Q16.16: reports overlap, or a hit with time of first
// contact within the frame.
// ---------------------------------------------------------------------------
// A new word is taken in every cycle; busy is always low. Each result is flagged
// by o_valid for one cycle, in the order of the starts. The path runs through the
// four bit-per-stage dividers (25 stages) plus five stages for setup and the final
// time comparison. Write configuration only when no word is in flight.
`include "swept_aabb_collision_test_defines.svh"
module swept_aabb_collision_test (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  saabb_pkg::t_in_word       i_item,
    output logic                      o_valid,
    output saabb_pkg::t_out_word      o_result,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [saabb_pkg::TW-1:0]  i_cfg_data
);
    import saabb_pkg::*;

    typedef struct packed {
        logic signed [CW:0] v;
        logic signed [CW:0] d1;   // bmin - amax
        logic signed [CW:0] d2;   // amin - bmax
        logic signed [CW:0] d3;   // bmax - amin
        logic signed [CW:0] d4;   // amax - bmin
    } t_ax1;

    typedef struct packed {
        logic [DW-1:0] mag;
        logic [DW-1:0] dent;
        logic [DW-1:0] dext;
        logic          ent;
        logic          ext;
        logic          ok;
        logic          sep;
    } t_ax2;

    typedef struct packed {
        logic vld;
        logic ovl;
        logic okx;
        logic oky;
        logic entx;
        logic extx;
        logic enty;
        logic exty;
    } t_side;

    logic [TW-1:0] r_frame_time;
    logic [EW-1:0] r_speed_eps;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_time <= FRAME_TIME_RST;
            r_speed_eps  <= SPEED_EPS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_TIME: r_frame_time <= i_cfg_data;
                CFG_SPEED_EPS:  r_speed_eps  <= i_cfg_data[EW-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    function automatic logic signed [CW:0] sx(input logic signed [CW-1:0] a);
        return {a[CW-1], a};
    endfunction

    function automatic logic gtz(input logic signed [CW:0] d);
        return !d[CW] && (d != '0);
    endfunction

    // Stage 1: relative velocity and corner distances per axis.
    logic r1_vld;
    t_ax1 r1_x, r1_y;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else          r1_vld <= start;
        r1_x.v  <= sx(i_item.b_vel_x) - sx(i_item.a_vel_x);
        r1_x.d1 <= sx(i_item.b_min_x) - sx(i_item.a_max_x);
        r1_x.d2 <= sx(i_item.a_min_x) - sx(i_item.b_max_x);
        r1_x.d3 <= sx(i_item.b_max_x) - sx(i_item.a_min_x);
        r1_x.d4 <= sx(i_item.a_max_x) - sx(i_item.b_min_x);
        r1_y.v  <= sx(i_item.b_vel_y) - sx(i_item.a_vel_y);
        r1_y.d1 <= sx(i_item.b_min_y) - sx(i_item.a_max_y);
        r1_y.d2 <= sx(i_item.a_min_y) - sx(i_item.b_max_y);
        r1_y.d3 <= sx(i_item.b_max_y) - sx(i_item.a_min_y);
        r1_y.d4 <= sx(i_item.a_max_y) - sx(i_item.b_min_y);
    end

    // Per-axis classification: speed, direction and which times are needed.
    function automatic t_ax2 classify(input t_ax1 a, input logic [EW-1:0] eps);
        t_ax2               r;
        logic signed [CW:0] m;
        logic               neg;
        logic               stat;
        logic               miss;
        neg   = a.v[CW];
        m     = neg ? -a.v : a.v;
        stat  = (a.v == '0) || ({1'b0, m[DW-1:0]} < (DW + 1)'(eps));
        r.sep = gtz(a.d1) || gtz(a.d2);
        r.mag = m[DW-1:0];
        if (neg) begin
            miss   = gtz(a.d2);
            r.ent  = gtz(a.d1);
            r.ext  = gtz(a.d3);
            r.dent = a.d1[DW-1:0];
            r.dext = a.d3[DW-1:0];
        end else begin
            miss   = gtz(a.d1);
            r.ent  = gtz(a.d2);
            r.ext  = gtz(a.d4);
            r.dent = a.d2[DW-1:0];
            r.dext = a.d4[DW-1:0];
        end
        if (stat) begin
            r.ent = 1'b0;
            r.ext = 1'b0;
            r.ok  = !r.sep;
        end else begin
            r.ok  = !miss;
        end
        return r;
    endfunction

    // Stage 2: classified axes feed the dividers.
    logic r2_vld;
    t_ax2 r2_x, r2_y;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else          r2_vld <= r1_vld;
        r2_x <= classify(r1_x, r_speed_eps);
        r2_y <= classify(r1_y, r_speed_eps);
    end

    // Dividers for entry and exit times on both axes.
    logic [QW-1:0] q_entx, q_extx, q_enty, q_exty;
    saabb_div u_div_entx (.i_clk(i_clk), .i_num({r2_x.dent, {FRAC_BITS{1'b0}}}),
                          .i_den(r2_x.mag), .o_quot(q_entx));
    saabb_div u_div_extx (.i_clk(i_clk), .i_num({r2_x.dext, {FRAC_BITS{1'b0}}}),
                          .i_den(r2_x.mag), .o_quot(q_extx));
    saabb_div u_div_enty (.i_clk(i_clk), .i_num({r2_y.dent, {FRAC_BITS{1'b0}}}),
                          .i_den(r2_y.mag), .o_quot(q_enty));
    saabb_div u_div_exty (.i_clk(i_clk), .i_num({r2_y.dext, {FRAC_BITS{1'b0}}}),
                          .i_den(r2_y.mag), .o_quot(q_exty));

    // Side information follows the divider stages.
    t_side r_side [0:DIV_LAT-1];
    t_side n_side;
    always_comb begin
        n_side.vld  = r2_vld;
        n_side.ovl  = !(r2_x.sep || r2_y.sep);
        n_side.okx  = r2_x.ok;
        n_side.oky  = r2_y.ok;
        n_side.entx = r2_x.ent;
        n_side.extx = r2_x.ext;
        n_side.enty = r2_y.ent;
        n_side.exty = r2_y.ext;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) r_side[i] <= '0;
        end else begin
            r_side[0] <= n_side;
            for (int i = 1; i < DIV_LAT; i++) r_side[i] <= r_side[i-1];
        end
    end

    // Stage 3: per-axis entry and exit times.
    logic [QW-1:0] ft_q;
    assign ft_q = QW'(r_frame_time);
    t_side         r3_side;
    logic [QW-1:0] r3_tfx, r3_tlx, r3_tfy, r3_tly;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_side <= '0;
        else          r3_side <= r_side[DIV_LAT-1];
        r3_tfx <= r_side[DIV_LAT-1].entx ? q_entx : '0;
        r3_tfy <= r_side[DIV_LAT-1].enty ? q_enty : '0;
        r3_tlx <= (r_side[DIV_LAT-1].extx && q_extx < ft_q) ? q_extx : ft_q;
        r3_tly <= (r_side[DIV_LAT-1].exty && q_exty < ft_q) ? q_exty : ft_q;
    end

    // Stage 4: latest entry and earliest exit across the axes.
    logic          r4_vld, r4_ovl, r4_ok;
    logic [QW-1:0] r4_tf, r4_tl;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_vld <= 1'b0;
        else          r4_vld <= r3_side.vld;
        r4_ovl <= r3_side.ovl;
        r4_ok  <= r3_side.okx && r3_side.oky;
        r4_tf  <= (r3_tfx > r3_tfy) ? r3_tfx : r3_tfy;
        r4_tl  <= (r3_tlx < r3_tly) ? r3_tlx : r3_tly;
    end

    // Stage 5: decision and result word.
    logic meet;
    assign meet = !r4_ovl && r4_ok && (r4_tf <= r4_tl);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r4_vld;
        o_result.hit                 <= r4_ovl || meet;
        o_result.already_overlapping <= r4_ovl;
        o_result.t_first             <= meet ? r4_tf[TW-1:0] : '0;
    end

    // Checks.
    `ASSERT_DELAYED(a_latency, i_clk, i_rst_n, start, LATENCY, o_valid)
    `ASSERT_IMPLIES(a_overlap_zero, i_clk, i_rst_n, o_valid && o_result.already_overlapping, o_result.hit && o_result.t_first == '0)
    `ASSERT_IMPLIES(a_miss_zero, i_clk, i_rst_n, o_valid && !o_result.hit, o_result.t_first == '0)
    `ASSERT_IMPLIES(a_in_frame, i_clk, i_rst_n, o_valid && !i_cfg_we && !$past(i_cfg_we), o_result.t_first <= r_frame_time)

endmodule

// File: hdl/saabb_div.sv
// ---------------------------------------------------------------------------
// Saturating pipelined divider
// Computes (num / den) one quotient bit per stage; a quotient that does not
// fit in QW bits comes out as all ones.
// ---------------------------------------------------------------------------
module saabb_div (
    input  logic                    i_clk,
    input  logic [saabb_pkg::NW-1:0] i_num,
    input  logic [saabb_pkg::DW-1:0] i_den,
    output logic [saabb_pkg::QW-1:0] o_quot
);
    import saabb_pkg::*;

    logic [RW-1:0] r_rem [0:QW];
    logic [DW-1:0] r_den [0:QW];
    logic [QW-1:0] r_quo [0:QW];
    logic          r_sat [0:QW];

    // Entry stage: flag quotients that overflow the result width.
    always_ff @(posedge i_clk) begin
        r_rem[0] <= RW'(i_num);
        r_den[0] <= i_den;
        r_quo[0] <= '0;
        r_sat[0] <= (RW'(i_num) >= {i_den, {QW{1'b0}}});
    end

    // One restoring step per stage, most significant bit first.
    for (genvar s = 0; s < QW; s++) begin : g_step
        logic [RW-1:0] shifted;
        logic [RW:0]   diff;
        assign shifted = RW'(r_den[s]) << (QW - 1 - s);
        assign diff    = {1'b0, r_rem[s]} - {1'b0, shifted};
        always_ff @(posedge i_clk) begin
            r_rem[s+1] <= diff[RW] ? r_rem[s] : diff[RW-1:0];
            r_den[s+1] <= r_den[s];
            r_quo[s+1] <= {r_quo[s][QW-2:0], ~diff[RW]};
            r_sat[s+1] <= r_sat[s];
        end
    end

    assign o_quot = r_sat[QW] ? {QW{1'b1}} : r_quo[QW];

endmodule
